>>> hdl/m3bh_pkg.sv
// Package for the MurmurHash3 x86_32 bucket hasher.
// Holds mixing constants, the sequencer state type and the rotate helpers.
// No dependencies.
package m3bh_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;
    localparam logic [31:0] MIX_M5  = 32'd5;
    localparam logic [31:0] SEED_RESET = 32'd23;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BK1,
        S_BK2,
        S_BK3,
        S_BK4,
        S_T1,
        S_T2,
        S_F1,
        S_F2,
        S_F3,
        S_MQ,
        S_MOD,
        S_DONE
    } t_state;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

endpackage

>>> hdl/m3bh_mul.sv
// Shared 32x32 multiplier with registered 64-bit product, given as low and high halves.
// Used by the hasher sequencer for every multiply step. No dependencies.
module m3bh_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_prod,
    output logic [31:0] o_prod_hi
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_prod    = r_prod[31:0];
    assign o_prod_hi = r_prod[63:32];

endmodule

>>> hdl/murmur3_bucket_hash_top.sv
// MurmurHash3 x86_32 bucket hasher, top level; uses m3bh_pkg and m3bh_mul.
// Input: a byte that does not complete a block is taken in idle; a byte that completes a
// block is mixed in states BK1 to BK4 through the shared multiplier; input stalls until idle.
// Last item: tail T1, T2 (BK1 to BK4 if its byte completes a block, none with no tail), then
// finalizer F1 to F3, reciprocal remainder MQ and MOD, load in done; waits while output stalls.
// Reset: synchronous active low; seed returns to 23, key state and output valid clear.
module murmur3_bucket_hash_top
    import m3bh_pkg::*;
#(
    parameter int BUCKET_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_full_hash,
    output logic [4:0]  o_bucket,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam logic [31:0] BC32  = 32'(BUCKET_COUNT);
    localparam logic [31:0] RECIP = 32'(64'hffff_ffff / 64'(BUCKET_COUNT));

    t_state r_state, n_state;

    logic [31:0] r_seed;
    logic [31:0] r_acc;
    logic [31:0] r_gather;
    logic [1:0]  r_phase;
    logic [31:0] r_len;
    logic        r_last;
    logic [31:0] r_h;
    logic [4:0]  r_rem;
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic [4:0]  r_out_bucket;

    logic [31:0] mul_a, mul_b, prod, prod_hi;
    logic        in_xfer, cfg_xfer, out_xfer, out_load;
    logic [31:0] gather_in;
    logic [1:0]  phase_in;
    logic [31:0] fin_x, fin_y, fin_h, blk_x;
    logic [31:0] mod_r0;
    logic [31:0] mod_fix;

    m3bh_mul u_mul (
        .i_clk     (i_clk),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_prod    (prod),
        .o_prod_hi (prod_hi)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_DONE) && !(r_out_valid && i_out_stall);

    assign gather_in = r_gather | (32'(i_key_byte) << {r_phase, 3'b000});
    assign phase_in  = r_phase + 2'd1;

    assign blk_x = r_acc ^ prod;
    assign fin_x = ((r_phase != 2'd0) ? (r_acc ^ prod) : r_acc) ^ r_len;
    assign fin_y = prod ^ (prod >> 13);
    assign fin_h = prod ^ (prod >> 16);

    assign mod_r0  = r_h - prod;
    assign mod_fix = (mod_r0 >= BC32) ? (mod_r0 - BC32) : mod_r0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_has_byte && (phase_in == 2'd0)) begin
                        n_state = S_BK1;
                    end else if (i_last) begin
                        n_state = (i_has_byte || (r_phase != 2'd0)) ? S_T1 : S_F1;
                    end
                end
            end
            S_BK1:  n_state = S_BK2;
            S_BK2:  n_state = S_BK3;
            S_BK3:  n_state = S_BK4;
            S_BK4:  n_state = r_last ? S_F1 : S_IDLE;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = S_MQ;
            S_MQ:   n_state = S_MOD;
            S_MOD:  n_state = S_DONE;
            S_DONE: n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a = r_gather;
        mul_b = MIX_C1;
        unique case (r_state)
            S_BK1, S_T1: begin
                mul_a = r_gather;
                mul_b = MIX_C1;
            end
            S_BK2, S_T2: begin
                mul_a = rotl15(prod);
                mul_b = MIX_C2;
            end
            S_BK3: begin
                mul_a = rotl13(blk_x);
                mul_b = MIX_M5;
            end
            S_F1: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = FIN_M1;
            end
            S_F2: begin
                mul_a = fin_y;
                mul_b = FIN_M2;
            end
            S_F3: begin
                mul_a = fin_h;
                mul_b = RECIP;
            end
            S_MQ: begin
                mul_a = prod_hi;
                mul_b = BC32;
            end
            default: begin
                mul_a = r_gather;
                mul_b = MIX_C1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_acc       <= SEED_RESET;
            r_gather    <= '0;
            r_phase     <= '0;
            r_len       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_xfer) begin
                r_seed <= i_cfg_data;
                if (r_len == 32'd0) begin
                    r_acc <= i_cfg_data;
                end
            end
            if (in_xfer) begin
                r_last <= i_last;
                if (i_has_byte) begin
                    r_gather <= gather_in;
                    r_phase  <= phase_in;
                    r_len    <= r_len + 32'd1;
                end
            end
            case (r_state)
                S_BK3: r_acc <= blk_x;
                S_BK4: begin
                    r_acc    <= prod + MIX_ADD;
                    r_gather <= '0;
                end
                S_F3: begin
                    r_acc    <= r_seed;
                    r_gather <= '0;
                    r_phase  <= '0;
                    r_len    <= '0;
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_F3) begin
            r_h <= fin_h;
        end
        if (r_state == S_MOD) begin
            r_rem <= mod_fix[4:0];
        end
        if (out_load) begin
            r_out_hash   <= r_h;
            r_out_bucket <= r_rem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_full_hash = r_out_hash;
    assign o_bucket    = r_out_bucket;

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result not loaded on leaving done state");

    a_block_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BK4) |-> (r_phase == 2'd0))
        else $error("block mixed with partial gather");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_len == 32'd0)) |-> ((r_phase == 2'd0) && (r_gather == 32'd0)))
        else $error("key state not cleared at key start");

    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

endmodule

>>> test/murmur3_bucket_hash_top_tb.sv
`timescale 1ns / 100ps
// Testbench for murmur3_bucket_hash_top: streams keys a byte per transfer and checks hash and
// bucket against a behavioral MurmurHash3 x86_32 model, with bursty input and output stalls.
// Depends on m3bh_pkg for the mixing constants and the reset seed.
module murmur3_bucket_hash_top_tb
    import m3bh_pkg::*;
();

    localparam int BUCKET_COUNT = 32;
    localparam int CLK_HALF = 6;
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 600;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;
    localparam int FILL_ALT = 3;

    typedef struct packed {
        logic [31:0] hash;
        logic [4:0]  bucket;
    } t_hash_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_key_byte = 8'd0;
    logic        i_has_byte = 1'b0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_full_hash;
    logic [4:0]  o_bucket;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = 32'd0;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;

    assign in_fire = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    murmur3_bucket_hash_top #(
        .BUCKET_COUNT(BUCKET_COUNT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_key_byte (i_key_byte),
        .i_has_byte (i_has_byte),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_full_hash(o_full_hash),
        .o_bucket   (o_bucket),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    logic [31:0] seed_value;
    logic [31:0] mix_acc;
    logic [31:0] gather_word;
    logic [1:0]  gather_count;
    logic [31:0] key_len;

    t_hash_result pending_hashes[$];

    int mismatches = 0;
    int keys_hashed = 0;
    int key_items = 0;
    int seed_writes = 0;
    int mid_key_writes = 0;
    int burst_left = 0;
    bit valid_held = 1'b0;
    int unsigned cycle_count = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] scramble_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rot_left(t, 15);
        t = t * MIX_C2;
        return t;
    endfunction

    function automatic logic [31:0] finalize_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    function automatic logic [7:0] byte_for(input int fill, input int idx);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            FILL_ALT:  return idx[0] ? 8'h01 : 8'h80;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return SEED_RESET;
            default: return $urandom();
        endcase
    endfunction

    task automatic start_new_key();
        mix_acc = seed_value;
        gather_word = 32'd0;
        gather_count = 2'd0;
        key_len = 32'd0;
    endtask

    task automatic absorb_key_item(input logic [7:0] kb, input logic has, input logic lst);
        t_hash_result res;
        logic [31:0] h;
        logic [31:0] rem;
        if (has) begin
            gather_word = gather_word | ({24'd0, kb} << (8 * gather_count));
            key_len = key_len + 32'd1;
            gather_count = gather_count + 2'd1;
            if (gather_count == 2'd0) begin
                mix_acc = rot_left(mix_acc ^ scramble_block(gather_word), 13) * MIX_M5 + MIX_ADD;
                gather_word = 32'd0;
            end
        end
        if (lst) begin
            h = mix_acc;
            if (gather_count != 2'd0)
                h = h ^ scramble_block(gather_word);
            h = finalize_hash(h ^ key_len);
            rem = h % BUCKET_COUNT;
            res.hash = h;
            res.bucket = rem[4:0];
            pending_hashes.push_back(res);
            start_new_key();
        end
    endtask

    task automatic send_key_item(input logic [7:0] kb, input logic has, input logic lst);
        int gap;
        i_in_valid <= 1'b1;
        i_key_byte <= kb;
        i_has_byte <= has;
        i_last <= lst;
        valid_held = 1'b1;
        do @(posedge i_clk); while (!in_fire);
        absorb_key_item(kb, has, lst);
        if (has || lst)
            key_items++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_bytes(input int n, input int fill, input int idle_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < idle_pct)
                send_key_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_key_item(byte_for(fill, i), 1'b1, 1'b0);
        end
    endtask

    task automatic send_key(input int n, input int fill, input int idle_pct, input bit marker);
        bit use_marker;
        use_marker = marker || (n == 0);
        send_bytes(use_marker ? n : n - 1, fill, idle_pct);
        if (use_marker)
            send_key_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        else
            send_key_item(byte_for(fill, n - 1), 1'b1, 1'b1);
    endtask

    task automatic wait_for_results();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        burst_left = 0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
        seed_value = value;
        seed_writes++;
        if (key_len == 32'd0)
            mix_acc = value;
        else
            mid_key_writes++;
    endtask

    always @(posedge i_clk) begin
        t_hash_result exp_res;
        if (i_rst_n && out_fire) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected result hash %h bucket %0d", $time, o_full_hash, o_bucket);
                mismatches++;
            end else begin
                exp_res = pending_hashes.pop_front();
                keys_hashed++;
                if (o_full_hash !== exp_res.hash) begin
                    $display("%0t: full_hash expected %h actual %h",
                             $time, exp_res.hash, o_full_hash);
                    mismatches++;
                end
                if (o_bucket !== exp_res.bucket) begin
                    $display("%0t: bucket expected %0d actual %0d",
                             $time, exp_res.bucket, o_bucket);
                    mismatches++;
                end
            end
        end
    end

    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_run = 0;

    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(64, 256);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_run = $urandom_range(5, 20);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
            3: i_out_stall <= ~i_out_stall;
            default: i_out_stall <= 1'b0;
        endcase
    end

    task automatic test_empty_and_single();
        send_key(0, FILL_RANDOM, 0, 1'b1);
        send_key(1, FILL_ZERO, 0, 1'b0);
        send_key(1, FILL_ONES, 0, 1'b1);
    endtask

    task automatic test_tail_lengths();
        send_key(3, FILL_ONES, 0, 1'b0);
        send_key(4, FILL_ZERO, 0, 1'b1);
        send_key(5, FILL_ALT, 0, 1'b0);
    endtask

    task automatic test_idle_items();
        send_key_item(8'hff, 1'b0, 1'b0);
        send_key(2, FILL_ALT, 100, 1'b0);
    endtask

    task automatic test_seed_register();
        write_seed(32'h0000_0000);
        send_key(0, FILL_RANDOM, 0, 1'b1);
        write_seed(32'hffff_ffff);
        send_key(2, FILL_ONES, 0, 1'b0);
        send_bytes(2, FILL_RANDOM, 0);
        write_seed($urandom());
        send_key(2, FILL_RANDOM, 0, 1'b0);
        write_seed(SEED_RESET);
    endtask

    task automatic test_random_keys();
        int start_items;
        int next_seed_at;
        int len;
        int split;
        int sel;
        bit paused;
        start_items = key_items;
        next_seed_at = 100;
        paused = 1'b0;
        while (key_items - start_items < RANDOM_ITEMS) begin
            if (key_items - start_items >= next_seed_at) begin
                write_seed(pick_seed());
                next_seed_at += 100;
            end
            if (!paused && key_items - start_items >= 300) begin
                wait_for_results();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(0, 8);
            else if (sel < 95)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 64);
            if (len >= 2 && $urandom_range(0, 24) == 0) begin
                split = $urandom_range(1, len - 1);
                send_bytes(split, FILL_RANDOM, 8);
                write_seed(pick_seed());
                send_key(len - split, FILL_RANDOM, 8, $urandom_range(0, 2) == 0);
            end else begin
                send_key(len, FILL_RANDOM, 8, $urandom_range(0, 2) == 0);
            end
        end
    endtask

    initial begin
        seed_value = SEED_RESET;
        start_new_key();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_single();
        test_tail_lengths();
        test_idle_items();
        test_seed_register();
        test_random_keys();
        wait_for_results();
        $display("hashed %0d keys from %0d key transfers; %0d seed writes, %0d inside a key",
                 keys_hashed, key_items, seed_writes, mid_key_writes);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hdl/m3bh_pkg.sv
hdl/m3bh_mul.sv
hdl/murmur3_bucket_hash_top.sv
test/murmur3_bucket_hash_top_tb.sv
